/* src/nfrc_pkg.sv */
// Shared types and constants of the NAND flash register controller.
`timescale 1ns / 1ps
package nfrc_pkg;

   localparam int STORED_PAGE_BYTES = 528;

   // register window offsets
   localparam logic [12:0] OFF_ID       = 13'h1000;
   localparam logic [12:0] OFF_TEST     = 13'h1004;
   localparam logic [12:0] OFF_DEVSEL   = 13'h100A;
   localparam logic [12:0] OFF_CONFIG   = 13'h100E;
   localparam logic [12:0] OFF_REWIND   = 13'h101A;
   localparam logic [12:0] OFF_CMD      = 13'h1034;
   localparam logic [12:0] OFF_ADDR     = 13'h1036;
   localparam logic [12:0] OFF_CTRL     = 13'h1038;
   localparam logic [12:0] OFF_ECC      = 13'h1042;
   localparam logic [12:0] OFF_STATUS   = 13'h1074;
   localparam logic [12:0] OFF_READY    = 13'h107C;
   localparam logic [12:0] OFF_DATA_WIN = 13'h0800;

   // fixed read values
   localparam logic [15:0] VAL_ERASED = 16'h00FF;
   localparam logic [15:0] VAL_ID     = 16'h0200;
   localparam logic [15:0] VAL_STATUS = 16'hFDFF;
   localparam logic [15:0] VAL_READY  = 16'h0080;

   // flash commands
   localparam logic [7:0] CMD_RESET    = 8'hFF;
   localparam logic [7:0] CMD_ERASE1   = 8'h60;
   localparam logic [7:0] CMD_PROG1    = 8'h80;
   localparam logic [7:0] CMD_READ2    = 8'h30;
   localparam logic [7:0] CMD_PROG2    = 8'h11;
   localparam logic [7:0] CMD_ERASE2   = 8'hD0;

   typedef enum logic [1:0] {K_NOP, K_CONST, K_REG, K_DATA} kind_type;

   typedef enum logic [3:0] {
      R_NONE, R_TEST, R_CONFIG, R_DEVSEL, R_CTRL, R_ECC, R_REWIND, R_CMD, R_ADDR
   } reg_type;

   // one classified bus word
   typedef struct packed {
      logic        is_write;
      kind_type    kind;
      reg_type     sel;
      logic        wide;
      logic [15:0] value;
   } op_type;

   // back pressure seen by the front
   typedef struct packed {
      logic clearing;
      logic q_full;
   } stall_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_EXEC, ST_RD, ST_RD_WAIT, ST_WR_HI,
      ST_SEEK_IDX, ST_SEEK_BASE, ST_ERASE_BASE, ST_ERASE, ST_DONE
   } state_type;

endpackage

/* src/nfrc_front.sv */
// Front end: accepts bus words and classifies them by offset.
`timescale 1ns / 1ps
module nfrc_front import nfrc_pkg::*; (
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [12:0] req_offset,
   input  logic        req_wide,
   input  logic [15:0] req_write_data,
   input  stall_type   stall,
   output logic        push,
   output op_type      op
);

   logic in_data;

   assign req_ready = !stall.clearing && !stall.q_full;
   assign push      = req_valid && req_ready;
   assign in_data   = (req_offset[12:9] == OFF_DATA_WIN[12:9]);

   // decode
   always_comb begin
      op          = '0;
      op.is_write = req_type;
      op.wide     = req_wide;
      op.kind     = K_NOP;
      op.sel      = R_NONE;
      if (req_type) begin
         op.value = req_write_data;
         if (in_data) begin
            op.kind = K_DATA;
         end else begin
            op.kind = K_REG;
            unique case (req_offset)
               OFF_REWIND: op.sel = R_REWIND;
               OFF_CMD:    op.sel = R_CMD;
               OFF_ADDR:   op.sel = R_ADDR;
               OFF_CTRL:   op.sel = R_CTRL;
               OFF_TEST:   op.sel = R_TEST;
               OFF_CONFIG: op.sel = R_CONFIG;
               OFF_DEVSEL: op.sel = R_DEVSEL;
               OFF_ECC:    op.sel = R_ECC;
               default:    op.kind = K_NOP;
            endcase
         end
      end else begin
         if (in_data) begin
            op.kind = K_DATA;
         end else if (req_offset < OFF_DATA_WIN) begin
            op.kind  = K_CONST;
            op.value = VAL_ERASED;
         end else begin
            op.kind = K_REG;
            unique case (req_offset)
               OFF_ID:     begin op.kind = K_CONST; op.value = VAL_ID;     end
               OFF_STATUS: begin op.kind = K_CONST; op.value = VAL_STATUS; end
               OFF_READY:  begin op.kind = K_CONST; op.value = VAL_READY;  end
               OFF_TEST:   op.sel = R_TEST;
               OFF_CONFIG: op.sel = R_CONFIG;
               OFF_DEVSEL: op.sel = R_DEVSEL;
               OFF_CTRL:   op.sel = R_CTRL;
               OFF_ECC:    op.sel = R_ECC;
               default:    op.kind = K_CONST;
            endcase
         end
         if (!req_wide) op.value[15:8] = 8'h00;
      end
   end

endmodule

/* src/nfrc_queue.sv */
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module nfrc_queue import nfrc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type op_in,
   output logic   full,
   input  logic   pop,
   output logic   empty,
   output op_type op_out
);

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full   = (count_ff == 2'd2);
   assign empty  = (count_ff == 2'd0);
   assign op_out = slot_ff[rd_ptr_ff];

   // pointer update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= op_in;
   end

endmodule

/* src/nfrc_back.sv */
// Back end: registers, byte store, seek and erase sequencing, result word.
`timescale 1ns / 1ps
module nfrc_back import nfrc_pkg::*; #(
   parameter int MAX_BLOCKS      = 16,
   parameter int PAGES_PER_BLOCK = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_write_data,
   input  logic        q_empty,
   input  op_type      op,
   output logic        pop,
   output logic        clearing,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_read_data
);

   localparam int BLOCK_BYTES = PAGES_PER_BLOCK * STORED_PAGE_BYTES;
   localparam int STORE_BYTES = MAX_BLOCKS * BLOCK_BYTES;
   localparam int MEM_AW      = $clog2(STORE_BYTES);
   localparam int PIW         = $clog2(MAX_BLOCKS * PAGES_PER_BLOCK + 64);
   localparam int PTR_W       = $clog2((MAX_BLOCKS * PAGES_PER_BLOCK + 64)
                                       * STORED_PAGE_BYTES + 1);
   localparam int LW          = $clog2(MAX_BLOCKS + 1);
   localparam int CW          = (LW > 5) ? LW : 5;

   // byte store
   logic [7:0]        mem [STORE_BYTES];
   logic              mem_we;
   logic [MEM_AW-1:0] mem_wa, mem_ra;
   logic [7:0]        mem_wd, mem_q;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q <= mem[mem_ra];
   end

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [4:0]        blocks_ff, blocks_in;
   logic [PTR_W-1:0]  page_base_ff, page_base_in;
   logic [PTR_W-1:0]  cursor_ff, cursor_in;
   logic              two_byte_ff, two_byte_in;
   logic [7:0]        addr_ff [3];
   logic [7:0]        addr_in [3];
   logic [2:0]        addr_cnt_ff, addr_cnt_in;
   logic [7:0]        ctrl_ff, ctrl_in;
   logic [7:0]        test_ff, test_in;
   logic [7:0]        config_ff, config_in;
   logic [7:0]        devsel_ff, devsel_in;
   logic [7:0]        ecc_ff, ecc_in;
   logic              hit_ff, hit_in;
   logic              second_ff, second_in;
   logic [15:0]       result_ff, result_in;
   logic [PIW-1:0]    page_idx_ff, page_idx_in;
   logic [MEM_AW-1:0] sweep_addr_ff, sweep_addr_in;
   logic [MEM_AW-1:0] sweep_left_ff, sweep_left_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;

   logic [LW-1:0]     live;
   logic [PTR_W-1:0]  store_size;
   logic [23:0]       sector;
   logic              blk_ok;
   logic [LW-1:0]     blk_sel;
   logic              cur_hit;
   logic [7:0]        rd_byte;
   logic [7:0]        cmd;

   assign clearing      = (state_ff == ST_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // store geometry
   always_comb begin
      live       = (CW'(blocks_ff) > CW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS) : LW'(blocks_ff);
      store_size = PTR_W'(live) * PTR_W'(BLOCK_BYTES);
      sector     = {addr_ff[2], addr_ff[1], addr_ff[0]};
      blk_ok     = sector[23:6] < 18'(live);
      blk_sel    = sector[6 +: LW];
      cur_hit    = cursor_ff < store_size;
      rd_byte    = hit_ff ? mem_q : 8'hFF;
      cmd        = op_ff.value[7:0];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      blocks_in     = csr_write_enable ? csr_write_data : blocks_ff;
      page_base_in  = page_base_ff;
      cursor_in     = cursor_ff;
      two_byte_in   = two_byte_ff;
      addr_in       = addr_ff;
      addr_cnt_in   = addr_cnt_ff;
      ctrl_in       = ctrl_ff;
      test_in       = test_ff;
      config_in     = config_ff;
      devsel_in     = devsel_ff;
      ecc_in        = ecc_ff;
      hit_in        = hit_ff;
      second_in     = second_ff;
      result_in     = result_ff;
      page_idx_in   = page_idx_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_left_in = sweep_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = cursor_ff[MEM_AW-1:0];
      mem_wd        = op_ff.value[7:0];
      mem_ra        = cursor_ff[MEM_AW-1:0];

      unique case (state_ff)
         ST_CLEAR, ST_ERASE: begin
            mem_we = 1'b1;
            mem_wa = sweep_addr_ff;
            mem_wd = 8'hFF;
            sweep_addr_in = sweep_addr_ff + 1'b1;
            sweep_left_in = sweep_left_ff - 1'b1;
            if (sweep_left_ff == '0) state_in = (state_ff == ST_CLEAR) ? ST_IDLE : ST_DONE;
         end
         ST_IDLE: begin
            if (!q_empty) begin
               pop       = 1'b1;
               op_in     = op;
               result_in = '0;
               second_in = 1'b0;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            priority case (op_ff.kind)
               K_CONST: result_in = op_ff.value;
               K_DATA: begin
                  if (op_ff.is_write) begin
                     if (cur_hit) begin
                        mem_we    = 1'b1;
                        cursor_in = cursor_ff + 1'b1;
                     end
                     if (two_byte_ff) state_in = ST_WR_HI;
                  end else begin
                     hit_in = cur_hit;
                     if (cur_hit) cursor_in = cursor_ff + 1'b1;
                     state_in = ST_RD_WAIT;
                  end
               end
               K_REG: begin
                  if (!op_ff.is_write) begin
                     priority case (op_ff.sel)
                        R_TEST:   result_in = {8'h00, test_ff};
                        R_CONFIG: result_in = {8'h00, config_ff};
                        R_DEVSEL: result_in = {8'h00, devsel_ff};
                        R_CTRL:   result_in = {8'h00, ctrl_ff | 8'h01};
                        R_ECC:    result_in = {8'h00, ecc_ff & 8'h7F};
                        default:  result_in = '0;
                     endcase
                  end else begin
                     priority case (op_ff.sel)
                        R_TEST:   test_in   = cmd;
                        R_CONFIG: config_in = cmd;
                        R_DEVSEL: devsel_in = cmd;
                        R_CTRL:   ctrl_in   = cmd & 8'hFE;
                        R_ECC:    ecc_in    = cmd;
                        R_REWIND: begin
                           if (op_ff.value[12:0] == OFF_DATA_WIN) cursor_in = page_base_ff;
                        end
                        R_ADDR: begin
                           if (addr_cnt_ff < 3'd3) addr_in[addr_cnt_ff[1:0]] = cmd;
                           if (addr_cnt_ff != 3'd7) addr_cnt_in = addr_cnt_ff + 1'b1;
                        end
                        R_CMD: begin
                           if (cmd == CMD_RESET || cmd == CMD_ERASE1 || cmd == CMD_PROG1) begin
                              addr_cnt_in = '0;
                           end else if (cmd == CMD_READ2 || cmd == CMD_PROG2) begin
                              state_in = ST_SEEK_IDX;
                           end else if (cmd == CMD_ERASE2) begin
                              state_in = ST_ERASE_BASE;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
               default: ;
            endcase
         end
         ST_RD: begin
            hit_in = cur_hit;
            if (cur_hit) cursor_in = cursor_ff + 1'b1;
            state_in = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            if (second_ff) begin
               result_in[15:8] = rd_byte;
               state_in = ST_DONE;
            end else begin
               result_in[7:0] = rd_byte;
               second_in = 1'b1;
               state_in  = op_ff.wide ? ST_RD : ST_DONE;
            end
         end
         ST_WR_HI: begin
            mem_wd = op_ff.value[15:8];
            if (cur_hit) begin
               mem_we    = 1'b1;
               cursor_in = cursor_ff + 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_SEEK_IDX: begin
            page_idx_in = PIW'(blk_sel) * PIW'(PAGES_PER_BLOCK) + PIW'(sector[5:0]);
            addr_cnt_in = '0;
            if (blk_ok) begin
               state_in = ST_SEEK_BASE;
            end else begin
               page_base_in = store_size;
               cursor_in    = store_size;
               state_in     = ST_DONE;
            end
         end
         ST_SEEK_BASE: begin
            page_base_in = PTR_W'(page_idx_ff) * PTR_W'(STORED_PAGE_BYTES);
            cursor_in    = PTR_W'(page_idx_ff) * PTR_W'(STORED_PAGE_BYTES);
            two_byte_in  = 1'b1;
            state_in     = ST_DONE;
         end
         ST_ERASE_BASE: begin
            addr_cnt_in   = '0;
            sweep_addr_in = MEM_AW'(blk_sel) * MEM_AW'(BLOCK_BYTES);
            sweep_left_in = MEM_AW'(BLOCK_BYTES - 1);
            state_in      = blk_ok ? ST_ERASE : ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         blocks_ff     <= 5'd16;
         page_base_ff  <= '0;
         cursor_ff     <= '0;
         two_byte_ff   <= 1'b0;
         addr_ff       <= '{default: 8'h00};
         addr_cnt_ff   <= '0;
         ctrl_ff       <= 8'h10;
         test_ff       <= '0;
         config_ff     <= '0;
         devsel_ff     <= '0;
         ecc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         sweep_addr_ff <= '0;
         sweep_left_ff <= MEM_AW'(STORE_BYTES - 1);
      end else begin
         state_ff      <= state_in;
         blocks_ff     <= blocks_in;
         page_base_ff  <= page_base_in;
         cursor_ff     <= cursor_in;
         two_byte_ff   <= two_byte_in;
         addr_ff       <= addr_in;
         addr_cnt_ff   <= addr_cnt_in;
         ctrl_ff       <= ctrl_in;
         test_ff       <= test_in;
         config_ff     <= config_in;
         devsel_ff     <= devsel_in;
         ecc_ff        <= ecc_in;
         rsp_valid_ff  <= rsp_valid_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_left_ff <= sweep_left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      hit_ff      <= hit_in;
      second_ff   <= second_in;
      result_ff   <= result_in;
      page_idx_ff <= page_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* src/nand_flash_register_controller_core.sv */
// Top level of the NAND flash register controller.
// Serves one bus word at a time against a 13-bit register window backed by a
// byte store of MAX_BLOCKS x PAGES_PER_BLOCK x 528 bytes with one write and
// one read port. After reset the store is swept to 0xFF one byte per cycle,
// with req_ready low. Each word then passes through the back end, which moves
// data bytes to and from the store one at a time, reads through the store's
// registered output and may wait for the result register to free up; a seek
// works out the page index and then the page base (only the index step when
// its block is out of range), and an erase sweeps its block of
// PAGES_PER_BLOCK * 528 bytes to 0xFF unless it is out of range.
// A two-entry queue lets the bus side run ahead of the back end.
`timescale 1ns / 1ps
module nand_flash_register_controller_core import nfrc_pkg::*; #(
   parameter int MAX_BLOCKS      = 16,
   parameter int PAGES_PER_BLOCK = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [12:0] req_offset,
   input  logic        req_wide,
   input  logic [15:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_read_data
);

   stall_type stall;
   op_type    front_op, back_op;
   logic      push, pop, q_full, q_empty, clearing;

   assign stall.clearing = clearing;
   assign stall.q_full   = q_full;

   nfrc_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_offset     (req_offset),
      .req_wide       (req_wide),
      .req_write_data (req_write_data),
      .stall          (stall),
      .push           (push),
      .op             (front_op)
   );

   nfrc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .op_in  (front_op),
      .full   (q_full),
      .pop    (pop),
      .empty  (q_empty),
      .op_out (back_op)
   );

   nfrc_back #(
      .MAX_BLOCKS      (MAX_BLOCKS),
      .PAGES_PER_BLOCK (PAGES_PER_BLOCK)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_empty          (q_empty),
      .op               (back_op),
      .pop              (pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data)
   );

endmodule
